[hdl/mrma_pkg.sv]
// Shared constants for the multichannel rectified moving average unit.
`default_nettype none

package mrma_pkg;

    localparam int CH_W         = 3;
    localparam int SAMPLE_W     = 16;
    localparam int MAG_W        = 16;
    localparam int FRAC_W       = 4;
    localparam int OUT_W        = 20;
    localparam int DEF_WINDOW   = 16;
    localparam int DEF_CHANNELS = 8;
    localparam int MAG_MAX      = 32768;

endpackage

`default_nettype wire

[hdl/multichannel_rectified_moving_average_unit.sv]
// Top level: per-channel rectified moving average with four fraction bits.
//
//   port group     | dir | handshake                   | payload
//   ---------------+-----+-----------------------------+-------------------------
//   sample word    | in  | sample_valid / sample_stall | channel, sample
//   result word    | out | result_valid / result_stall | out_channel, average_q4
//
// One word per cycle sustained while result_stall is low; from accept to result_valid the
// registered steps are channel state read, window read/write, sum update, reciprocal multiply.
// Channel state lives in a small RAM with valid bits; window magnitudes in a second RAM.
// Reset clears the channel valid bits and pipeline valid flags only; the RAMs are never cleared.
// A stalled result freezes the whole pipeline, so sample_stall follows result_stall
// while a result is held.
`default_nettype none

module multichannel_rectified_moving_average_unit #(
    parameter int WINDOW   = mrma_pkg::DEF_WINDOW,
    parameter int CHANNELS = mrma_pkg::DEF_CHANNELS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          sample_valid,
    output logic                               sample_stall,
    input  wire logic [mrma_pkg::CH_W-1:0]     channel,
    input  wire logic signed [mrma_pkg::SAMPLE_W-1:0] sample,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic      [mrma_pkg::CH_W-1:0]     out_channel,
    output logic      [mrma_pkg::OUT_W-1:0]    average_q4
);

    import mrma_pkg::*;

    localparam int CH_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WP_W    = $clog2(WINDOW);
    localparam int FILL_W  = $clog2(WINDOW + 1);
    localparam int SUM_W   = MAG_W + WP_W;
    localparam int WA_W    = CH_AW + WP_W;
    localparam int N_W     = SUM_W + FRAC_W;
    localparam int K       = N_W + WP_W;
    localparam int RECIP_W = N_W + 1;
    localparam int PROD_W  = N_W + RECIP_W;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP64);

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [WP_W-1:0]   wpos;
        logic [FILL_W-1:0] fill;
        logic [MAG_W-1:0]  prime;
    } chan_state_t;

    localparam int CS_W = $bits(chan_state_t);

    // pipeline control
    logic adv;
    logic accept;

    // input side
    logic [MAG_W-1:0] in_mag;
    logic             in_inr;

    // stage 1: channel state available
    logic             s1_valid_reg;
    logic [CH_W-1:0]  s1_ch_reg;
    logic [MAG_W-1:0] s1_mag_reg;
    logic             s1_inr_reg;
    logic             cr_rd_vld_reg;
    logic [CS_W-1:0]  cr_rdata;
    chan_state_t      cur;
    chan_state_t      s1_next;
    logic             s1_fwd_sum;
    logic [CH_AW-1:0] s1_ch_addr;

    // stage 2: window word available, sum update, state write
    logic             s2_valid_reg;
    logic [CH_W-1:0]  s2_ch_reg;
    logic [MAG_W-1:0] s2_mag_reg;
    logic             s2_inr_reg;
    logic             s2_first_reg;
    logic             s2_use_prime_reg;
    logic             s2_fwd_reg;
    chan_state_t      s2_state_reg;
    logic [MAG_W-1:0] wr_rdata;
    logic [SUM_W-1:0] sum_prev;
    logic [MAG_W-1:0] leaving;
    logic [SUM_W-1:0] sum_new;
    chan_state_t      wr_state;
    logic             cr_we;
    logic [CH_AW-1:0] s2_ch_addr;

    // last written channel entry
    logic             wb_valid_reg;
    logic [CH_W-1:0]  wb_ch_reg;
    chan_state_t      wb_state_reg;

    // valid bits of the channel RAM
    logic [CHANNELS-1:0] vld_reg;
    logic [CHANNELS-1:0] vld_next;

    // stage 3: scale by 16 / WINDOW
    logic             s3_valid_reg;
    logic [CH_W-1:0]  s3_ch_reg;
    logic             s3_inr_reg;
    logic [SUM_W-1:0] s3_sum_reg;
    logic [PROD_W-1:0] prod;

    // output register
    logic             out_valid_reg;
    logic [CH_W-1:0]  out_ch_reg;
    logic [OUT_W-1:0] out_avg_reg;

    assign adv          = !(out_valid_reg && result_stall);
    assign accept       = sample_valid && adv;
    assign sample_stall = !adv;

    assign in_mag = sample[SAMPLE_W-1] ? MAG_W'(~sample + 1'b1) : MAG_W'(sample);
    assign in_inr = (32'(channel) < CHANNELS);

    // ---------------- channel state RAM ----------------
    assign s2_ch_addr = CH_AW'(s2_ch_reg);
    assign cr_we      = adv && s2_valid_reg && s2_inr_reg;

    mrma_ram #(
        .WIDTH (CS_W),
        .DEPTH (CHANNELS),
        .AW    (CH_AW)
    ) u_chan_ram (
        .clk   (clk),
        .we    (cr_we),
        .waddr (s2_ch_addr),
        .wdata (wr_state),
        .re    (accept),
        .raddr (CH_AW'(channel)),
        .rdata (cr_rdata)
    );

    always_comb
    begin
        vld_next = vld_reg;
        if (cr_we)
        begin
            vld_next[s2_ch_addr] = 1'b1;
        end
    end

    // ---------------- stage 1 ----------------
    // Newest copy wins: the word one stage ahead, then the last write, then the RAM.
    always_comb
    begin
        cur        = cr_rd_vld_reg ? chan_state_t'(cr_rdata) : '0;
        s1_fwd_sum = 1'b0;
        if (s2_valid_reg && s2_inr_reg && (s2_ch_reg == s1_ch_reg))
        begin
            cur.wpos   = s2_state_reg.wpos;
            cur.fill   = s2_state_reg.fill;
            cur.prime  = s2_state_reg.prime;
            s1_fwd_sum = 1'b1;
        end
        else if (wb_valid_reg && (wb_ch_reg == s1_ch_reg))
        begin
            cur = wb_state_reg;
        end
    end

    always_comb
    begin
        s1_next       = cur;
        s1_next.prime = (cur.fill == '0) ? s1_mag_reg : cur.prime;
        s1_next.wpos  = (cur.wpos == WP_W'(WINDOW - 1)) ? '0 : cur.wpos + 1'b1;
        s1_next.fill  = (cur.fill != FILL_W'(WINDOW)) ? cur.fill + 1'b1 : cur.fill;
    end

    assign s1_ch_addr = CH_AW'(s1_ch_reg);

    // Read-first: the slot being overwritten yields the magnitude leaving the window.
    mrma_ram #(
        .WIDTH (MAG_W),
        .DEPTH (2 ** WA_W),
        .AW    (WA_W)
    ) u_window_ram (
        .clk   (clk),
        .we    (adv && s1_valid_reg && s1_inr_reg),
        .waddr ({s1_ch_addr, cur.wpos}),
        .wdata (s1_mag_reg),
        .re    (adv && s1_valid_reg && s1_inr_reg),
        .raddr ({s1_ch_addr, cur.wpos}),
        .rdata (wr_rdata)
    );

    // ---------------- stage 2 ----------------
    assign sum_prev = s2_fwd_reg ? wb_state_reg.sum : s2_state_reg.sum;
    assign leaving  = s2_use_prime_reg ? s2_state_reg.prime : wr_rdata;

    always_comb
    begin
        if (s2_first_reg)
        begin
            sum_new = SUM_W'(WINDOW) * SUM_W'(s2_mag_reg);
        end
        else
        begin
            sum_new = sum_prev - SUM_W'(leaving) + SUM_W'(s2_mag_reg);
        end
        wr_state     = s2_state_reg;
        wr_state.sum = sum_new;
    end

    // ---------------- stage 3 ----------------
    assign prod = PROD_W'({s3_sum_reg, {FRAC_W{1'b0}}}) * PROD_W'(RECIP);

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cr_rd_vld_reg <= 1'b0;
            wb_valid_reg  <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (accept)
            begin
                cr_rd_vld_reg <= vld_reg[CH_AW'(channel)];
            end
            if (cr_we)
            begin
                wb_valid_reg <= 1'b1;
            end
            if (adv)
            begin
                s1_valid_reg  <= sample_valid;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (cr_we)
        begin
            wb_ch_reg    <= s2_ch_reg;
            wb_state_reg <= wr_state;
        end
        if (adv)
        begin
            s1_ch_reg  <= channel;
            s1_mag_reg <= in_mag;
            s1_inr_reg <= in_inr;

            s2_ch_reg        <= s1_ch_reg;
            s2_mag_reg       <= s1_mag_reg;
            s2_inr_reg       <= s1_inr_reg;
            s2_first_reg     <= (cur.fill == '0);
            s2_use_prime_reg <= (cur.fill != FILL_W'(WINDOW));
            s2_fwd_reg       <= s1_fwd_sum;
            s2_state_reg     <= s1_next;

            s3_ch_reg  <= s2_ch_reg;
            s3_inr_reg <= s2_inr_reg;
            s3_sum_reg <= sum_new;

            out_ch_reg  <= s3_ch_reg;
            out_avg_reg <= s3_inr_reg ? OUT_W'(prod >> K) : '0;
        end
    end

    assign result_valid = out_valid_reg;
    assign out_channel  = out_ch_reg;
    assign average_q4   = out_avg_reg;

    // ---------------- assertions ----------------
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        cr_we |-> (wr_state.fill != '0) && (32'(wr_state.fill) <= WINDOW))
        else $error("channel fill count out of range on write");

    a_wpos_range: assert property (@(posedge clk) disable iff (!rst_n)
        cr_we |-> (32'(wr_state.wpos) < WINDOW))
        else $error("write position beyond window");

    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cr_we |-> (wr_state.sum <= SUM_W'(WINDOW) * SUM_W'(MAG_MAX)))
        else $error("running sum exceeds window times largest magnitude");

    a_valid_set: assert property (@(posedge clk) disable iff (!rst_n)
        cr_we |=> vld_reg[$past(s2_ch_addr)])
        else $error("channel valid bit not set after state write");

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s2_valid_reg) |=> s3_valid_reg)
        else $error("word dropped between sum stage and scale stage");

endmodule

`default_nettype wire

[hdl/mrma_ram.sv]
// Generic single-write, single-read RAM with registered, read-first output.
`default_nettype none

module mrma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

`default_nettype wire
